// File: design/assert_macros.svh
// Assertion macros used by the top-level design file.
// Define ASSERT_OFF to compile all assertions away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define PSU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define PSU_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define PSU_ASSERT(label, prop, msg)
`define PSU_NEVER(label, cond, msg)
`endif
`endif

// File: design/psu_pkg.sv
package psu_pkg;

  // Sizes fixed by the item format
  localparam int unsigned DIMENSIONS_DEF = 32;
  localparam int unsigned IDX_W          = 5;
  localparam int unsigned VAL_W          = 32;
  localparam int unsigned RAND_W         = 17;
  localparam int unsigned CHI_W          = 17;
  localparam int unsigned GAIN_W         = 19;
  localparam int unsigned PADDR_W        = 4;

  // Register reset values
  localparam logic              MAXIMIZE_RST = 1'b0;
  localparam logic [CHI_W-1:0]  CHI_RST      = 17'd47748;
  localparam logic [GAIN_W-1:0] SELF_RST     = 19'd134349;
  localparam logic [GAIN_W-1:0] SOCIAL_RST   = 19'd134349;

  typedef enum logic [1:0] {
    REG_MAXIMIZE = 2'd0,
    REG_CHI      = 2'd1,
    REG_SELF     = 2'd2,
    REG_SOCIAL   = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    OP_LOAD_BOUNDS = 3'd0,
    OP_INIT_ELEM   = 3'd1,
    OP_INIT_FIT    = 3'd2,
    OP_MOVE        = 3'd3,
    OP_REPORT      = 3'd4,
    OP_SET_LOCAL   = 3'd5,
    OP_READ_BEST   = 3'd6
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_MULT,
    ST_SUM,
    ST_SCALE,
    ST_COMMIT,
    ST_COPY,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              maximize;
    logic [CHI_W-1:0]  chi;
    logic [GAIN_W-1:0] self_g;
    logic [GAIN_W-1:0] social_g;
  } cfg_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic mem_rd;
    logic diff;
    logic mult;
    logic sum;
    logic scale;
    logic commit;
    logic copy_start;
    logic copy_run;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [2:0] op;
    logic       idx_ok;
    logic       improve;
    logic       copy_busy;
    logic       out_free;
  } dp_sts_t;

  // Reverse and halve a velocity, rounding toward minus infinity.
  function automatic logic [VAL_W-1:0] half_neg(input logic [VAL_W-1:0] v);
    logic signed [VAL_W:0] n;
    n = -$signed({v[VAL_W-1], v});
    return n[VAL_W:1];
  endfunction

endpackage

// File: design/psu_regs.sv
module psu_regs import psu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;
  logic wr_en;
  reg_e sel;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign sel    = reg_e'(paddr[3:2]);
  assign cfg_o  = cfg_q;

  // Register writes complete in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.maximize <= MAXIMIZE_RST;
      cfg_q.chi      <= CHI_RST;
      cfg_q.self_g   <= SELF_RST;
      cfg_q.social_g <= SOCIAL_RST;
    end else if (wr_en) begin
      case (sel)
        REG_MAXIMIZE: cfg_q.maximize <= pwdata[0];
        REG_CHI:      cfg_q.chi      <= pwdata[CHI_W-1:0];
        REG_SELF:     cfg_q.self_g   <= pwdata[GAIN_W-1:0];
        REG_SOCIAL:   cfg_q.social_g <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (sel)
      REG_MAXIMIZE: prdata = {31'd0, cfg_q.maximize};
      REG_CHI:      prdata = {{(32-CHI_W){1'b0}}, cfg_q.chi};
      REG_SELF:     prdata = {{(32-GAIN_W){1'b0}}, cfg_q.self_g};
      REG_SOCIAL:   prdata = {{(32-GAIN_W){1'b0}}, cfg_q.social_g};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

// File: design/psu_ctrl.sv
module psu_ctrl import psu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   need_copy;

  assign need_copy = (sts_i.op == OP_INIT_FIT) || ((sts_i.op == OP_REPORT) && sts_i.improve);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_READ;
      ST_READ: begin
        if ((sts_i.op == OP_MOVE) && sts_i.idx_ok) state_d = ST_DIFF;
        else                                       state_d = ST_COMMIT;
      end
      ST_DIFF:   state_d = ST_MULT;
      ST_MULT:   state_d = ST_SUM;
      ST_SUM:    state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_COMMIT;
      ST_COMMIT: state_d = need_copy ? ST_COPY : ST_DONE;
      ST_COPY:   if (!sts_i.copy_busy) state_d = ST_DONE;
      ST_DONE:   if (sts_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_READ:  cmd_o.mem_rd = 1'b1;
      ST_DIFF:  cmd_o.diff   = 1'b1;
      ST_MULT:  cmd_o.mult   = 1'b1;
      ST_SUM:   cmd_o.sum    = 1'b1;
      ST_SCALE: cmd_o.scale  = 1'b1;
      ST_COMMIT: begin
        cmd_o.commit     = 1'b1;
        cmd_o.copy_start = need_copy;
      end
      ST_COPY:  cmd_o.copy_run = 1'b1;
      ST_DONE:  cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

// File: design/psu_dp.sv
module psu_dp import psu_pkg::*; #(
  parameter int unsigned DIMENSIONS = DIMENSIONS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  dp_cmd_t           cmd_i,
  output dp_sts_t           sts_o,
  // input item
  input  logic [2:0]        op_i,
  input  logic [IDX_W-1:0]  index_i,
  input  logic [VAL_W-1:0]  value_a_i,
  input  logic [VAL_W-1:0]  value_b_i,
  input  logic [VAL_W-1:0]  fitness_i,
  input  logic [RAND_W-1:0] rand_self_i,
  input  logic [RAND_W-1:0] rand_social_i,
  input  logic              use_global_i,
  // result item
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [IDX_W-1:0]  echo_index_o,
  output logic [VAL_W-1:0]  result_value_o,
  output logic [VAL_W-1:0]  best_fitness_o,
  output logic [VAL_W-1:0]  local_best_fitness_o,
  output logic              improved_o,
  output logic              bound_hit_o
);

  localparam int unsigned AW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
  localparam int unsigned CW = $clog2(DIMENSIONS + 1);

  // Latched item
  logic [2:0]        op_q;
  logic [IDX_W-1:0]  idx_q;
  logic [VAL_W-1:0]  va_q, vb_q, fit_q;
  logic [RAND_W-1:0] r1_q, r2_q;
  logic              ug_q;

  // Per-dimension stores
  logic [VAL_W-1:0] pos_mem [DIMENSIONS];
  logic [VAL_W-1:0] vel_mem [DIMENSIONS];
  logic [VAL_W-1:0] pb_mem  [DIMENSIONS];
  logic [VAL_W-1:0] lb_mem  [DIMENSIONS];
  logic [VAL_W-1:0] lo_mem  [DIMENSIONS];
  logic [VAL_W-1:0] hi_mem  [DIMENSIONS];
  logic [VAL_W-1:0] pos_rd_q, vel_rd_q, pb_rd_q, lb_rd_q, lo_rd_q, hi_rd_q;

  // Fitness state
  logic [VAL_W-1:0] pbf_q, lbv_q;

  // Copy sweep
  logic [CW-1:0] cnt_q;
  logic [AW-1:0] wr_addr_q;
  logic          wr_pend_q;
  logic          copy_rd;

  // Move pipeline
  logic        [19:0] k1_q, k2_q;
  logic signed [32:0] d1_q, d2_q;
  logic signed [37:0] t1_q, t2_q;
  logic signed [39:0] s_q;
  logic signed [41:0] sc_q;

  // Commit results
  logic [VAL_W-1:0] res_q;
  logic             imp_q, hit_q;

  // Output register
  logic             out_valid_q;
  logic [IDX_W-1:0] out_idx_q;
  logic [VAL_W-1:0] out_res_q, out_pbf_q, out_lbv_q;
  logic             out_imp_q, out_hit_q;

  logic [AW-1:0]    addr;
  logic             idx_ok, improve;
  logic [35:0]      pk1, pk2;
  logic [VAL_W-1:0] g_val;
  logic signed [53:0] pt1, pt2;
  logic signed [39:0] s_d;
  logic signed [57:0] pc;
  logic [VAL_W-1:0] v_sat, v_fin;
  logic signed [32:0] x_new, x_fin, lo33, hi33;
  logic             hit_d;

  assign addr    = AW'(idx_q);
  assign idx_ok  = (32'(idx_q) < 32'(DIMENSIONS));
  assign improve = cfg_i.maximize ? ($signed(fit_q) > $signed(pbf_q))
                                  : ($signed(fit_q) < $signed(pbf_q));
  assign copy_rd = cmd_i.copy_run && (cnt_q != CW'(DIMENSIONS));

  assign sts_o.op        = op_q;
  assign sts_o.idx_ok    = idx_ok;
  assign sts_o.improve   = improve;
  assign sts_o.copy_busy = (cnt_q != CW'(DIMENSIONS)) || wr_pend_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // Capture the accepted transaction.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_i;
      idx_q <= index_i;
      va_q  <= value_a_i;
      vb_q  <= value_b_i;
      fit_q <= fitness_i;
      r1_q  <= rand_self_i;
      r2_q  <= rand_social_i;
      ug_q  <= use_global_i;
    end
  end

  // Position and velocity store; position also feeds the copy sweep.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && idx_ok && (op_q == OP_INIT_ELEM)) begin
      pos_mem[addr] <= va_q;
      vel_mem[addr] <= vb_q;
    end else if (cmd_i.commit && idx_ok && (op_q == OP_MOVE)) begin
      pos_mem[addr] <= x_fin[VAL_W-1:0];
      vel_mem[addr] <= v_fin;
    end
    if (cmd_i.mem_rd) begin
      pos_rd_q <= pos_mem[addr];
      vel_rd_q <= vel_mem[addr];
    end else if (copy_rd) begin
      pos_rd_q <= pos_mem[cnt_q[AW-1:0]];
    end
  end

  // Bound store.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && idx_ok && (op_q == OP_LOAD_BOUNDS)) begin
      lo_mem[addr] <= va_q;
      hi_mem[addr] <= vb_q;
    end
    if (cmd_i.mem_rd) begin
      lo_rd_q <= lo_mem[addr];
      hi_rd_q <= hi_mem[addr];
    end
  end

  // Personal and local best stores.
  always_ff @(posedge clk_i) begin
    if (wr_pend_q) begin
      pb_mem[wr_addr_q] <= pos_rd_q;
      lb_mem[wr_addr_q] <= pos_rd_q;
    end else if (cmd_i.commit && idx_ok && (op_q == OP_SET_LOCAL)) begin
      lb_mem[addr] <= va_q;
    end
    if (cmd_i.mem_rd) begin
      pb_rd_q <= pb_mem[addr];
      lb_rd_q <= lb_mem[addr];
    end
  end

  // Copy sweep: read one position per cycle, write both bests in the cycle after.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= CW'(DIMENSIONS);
      wr_pend_q <= 1'b0;
      wr_addr_q <= '0;
    end else if (cmd_i.copy_start) begin
      cnt_q     <= '0;
      wr_pend_q <= 1'b0;
    end else begin
      wr_pend_q <= copy_rd;
      if (copy_rd) begin
        wr_addr_q <= cnt_q[AW-1:0];
        cnt_q     <= cnt_q + 1'b1;
      end
    end
  end

  // Move, first step: gain products and distances to the bests.
  assign pk1   = 36'(cfg_i.self_g) * 36'(r1_q);
  assign pk2   = 36'(cfg_i.social_g) * 36'(r2_q);
  assign g_val = ug_q ? va_q : lb_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff) begin
      k1_q <= pk1[35:16];
      k2_q <= pk2[35:16];
      d1_q <= $signed({pb_rd_q[VAL_W-1], pb_rd_q}) - $signed({pos_rd_q[VAL_W-1], pos_rd_q});
      d2_q <= $signed({g_val[VAL_W-1], g_val}) - $signed({pos_rd_q[VAL_W-1], pos_rd_q});
    end
  end

  // Move, second step: pulls scaled back by 16 bits (floor).
  assign pt1 = $signed({1'b0, k1_q}) * d1_q;
  assign pt2 = $signed({1'b0, k2_q}) * d2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mult) begin
      t1_q <= pt1[53:16];
      t2_q <= pt2[53:16];
    end
  end

  // Move, third step: velocity sum.
  assign s_d = $signed(vel_rd_q) + t1_q + t2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      s_q <= s_d;
    end
  end

  // Move, fourth step: constriction.
  assign pc = $signed({1'b0, cfg_i.chi}) * s_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      sc_q <= pc[57:16];
    end
  end

  // Move, last step: saturate, step the position and clamp to the bounds.
  always_comb begin
    if (sc_q[41:31] != {11{sc_q[41]}}) begin
      v_sat = sc_q[41] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      v_sat = sc_q[31:0];
    end
    lo33  = $signed({lo_rd_q[VAL_W-1], lo_rd_q});
    hi33  = $signed({hi_rd_q[VAL_W-1], hi_rd_q});
    x_new = $signed({pos_rd_q[VAL_W-1], pos_rd_q}) + $signed({v_sat[VAL_W-1], v_sat});
    x_fin = x_new;
    v_fin = v_sat;
    hit_d = 1'b0;
    if (x_fin < lo33) begin
      x_fin = lo33;
      v_fin = half_neg(v_fin);
      hit_d = 1'b1;
    end
    if (x_fin > hi33) begin
      x_fin = hi33;
      v_fin = half_neg(v_fin);
      hit_d = 1'b1;
    end
  end

  // Fitness state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pbf_q <= '0;
      lbv_q <= '0;
    end else if (cmd_i.commit) begin
      if ((op_q == OP_INIT_FIT) || ((op_q == OP_REPORT) && improve)) begin
        pbf_q <= fit_q;
        lbv_q <= fit_q;
      end else if (op_q == OP_SET_LOCAL) begin
        lbv_q <= fit_q;
      end
    end
  end

  // Result of the item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_q <= '0;
      imp_q <= (op_q == OP_REPORT) && improve;
      hit_q <= 1'b0;
      if ((op_q == OP_MOVE) && idx_ok) begin
        res_q <= x_fin[VAL_W-1:0];
        hit_q <= hit_d;
      end else if ((op_q == OP_READ_BEST) && idx_ok) begin
        res_q <= pb_rd_q;
      end
    end
  end

  // Output register: holds the transaction until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_idx_q <= idx_q;
      out_res_q <= res_q;
      out_pbf_q <= pbf_q;
      out_lbv_q <= lbv_q;
      out_imp_q <= imp_q;
      out_hit_q <= hit_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign echo_index_o         = out_idx_q;
  assign result_value_o       = out_res_q;
  assign best_fitness_o       = out_pbf_q;
  assign local_best_fitness_o = out_lbv_q;
  assign improved_o           = out_imp_q;
  assign bound_hit_o          = out_hit_q;

endmodule

// File: design/particle_swarm_update.sv
// Particle swarm update engine for one particle (constriction-factor form).
// Items arrive on the s_axis channel, one result per item leaves on m_axis.
// The four configuration registers sit behind the APB port; the user must write them
// only while the block is idle, a rule the block leaves unchecked. pready is always high.
// Each item steps through the controller states read, commit and done; a move
// of a valid dimension passes diff, mult, sum and scale between read and commit.
// Init fitness, or a report that improves the personal best, adds a copy state
// in which the whole position is copied into both best stores by a sweep of
// one dimension a cycle.
// A new item is accepted only once the previous one has left the done state.
// The move runs through a chain of registered multiplies (gain products,
// pulls, constriction); the copy sweep is set by the one-port stores.
// Reset clears the fitness values, the gains to their defaults and all
// control; the per-dimension stores hold nothing valid until written.
// A finished result waits in the output register while m_axis_tready is low;
// the next item is accepted meanwhile and is held before its own result.
`include "assert_macros.svh"
module particle_swarm_update import psu_pkg::*; #(
  parameter int unsigned DIMENSIONS = DIMENSIONS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input items
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // index, value_a, value_b, fitness, rand_self, rand_social, zero pad
  input  logic [135:0]       s_axis_tdata,
  // op, use_global
  input  logic [3:0]         s_axis_tuser,
  // result items
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // echo_index, result_value, best_fitness, local_best_fitness, zero pad
  output logic [103:0]       m_axis_tdata,
  // improved, bound_hit
  output logic [1:0]         m_axis_tuser,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t             cfg;
  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [IDX_W-1:0] echo_index;
  logic [VAL_W-1:0] result_value, best_fitness, local_best_fitness;
  logic             improved, bound_hit;

  psu_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  psu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  psu_dp #(
    .DIMENSIONS (DIMENSIONS)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .op_i                 (s_axis_tuser[2:0]),
    .index_i              (s_axis_tdata[4:0]),
    .value_a_i            (s_axis_tdata[36:5]),
    .value_b_i            (s_axis_tdata[68:37]),
    .fitness_i            (s_axis_tdata[100:69]),
    .rand_self_i          (s_axis_tdata[117:101]),
    .rand_social_i        (s_axis_tdata[134:118]),
    .use_global_i         (s_axis_tuser[3]),
    .out_ready_i          (m_axis_tready),
    .out_valid_o          (m_axis_tvalid),
    .echo_index_o         (echo_index),
    .result_value_o       (result_value),
    .best_fitness_o       (best_fitness),
    .local_best_fitness_o (local_best_fitness),
    .improved_o           (improved),
    .bound_hit_o          (bound_hit)
  );

  assign m_axis_tdata = {3'b000, local_best_fitness, best_fitness, result_value, echo_index};
  assign m_axis_tuser = {bound_hit, improved};

  // No new transaction is taken while the best stores are being rewritten.
  `PSU_NEVER(a_no_accept_in_copy, sts.copy_busy && s_axis_tready, "accept during copy sweep")
  // A result is only loaded into a free output register.
  `PSU_ASSERT(a_load_free, cmd.out_load |-> (!m_axis_tvalid || m_axis_tready), "result overwritten")
  // Only a fitness initialisation or an improving report starts a copy.
  `PSU_ASSERT(a_copy_cause, cmd.copy_start |-> (sts.op == OP_INIT_FIT || (sts.op == OP_REPORT && sts.improve)), "spurious copy")

endmodule

// File: tb/particle_swarm_update_tb.sv
module particle_swarm_update_tb;
  import psu_pkg::*;

  // Code that the block must treat as a no-operation.
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE_CYCLES = 2 * DIMENSIONS_DEF + 20;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct {
    logic [2:0]              op;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] val_a;
    logic signed [VAL_W-1:0] val_b;
    logic signed [VAL_W-1:0] fit;
    logic [RAND_W-1:0]       r_self;
    logic [RAND_W-1:0]       r_social;
    logic                    use_global;
  } swarm_cmd_t;

  typedef struct {
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] best_fit;
    logic signed [VAL_W-1:0] local_fit;
    logic                    improved;
    logic                    hit;
  } swarm_res_t;

  // Particle state mirror and the queue of results it predicts.
  class particle_scoreboard;
    logic signed [VAL_W-1:0] pos [DIMENSIONS_DEF];
    logic signed [VAL_W-1:0] vel [DIMENSIONS_DEF];
    logic signed [VAL_W-1:0] pbest [DIMENSIONS_DEF];
    logic signed [VAL_W-1:0] lbest [DIMENSIONS_DEF];
    logic signed [VAL_W-1:0] lo_b [DIMENSIONS_DEF];
    logic signed [VAL_W-1:0] hi_b [DIMENSIONS_DEF];
    logic signed [VAL_W-1:0] cur_fit, best_fit, local_fit;
    logic              maximize;
    logic [CHI_W-1:0]  chi;
    logic [GAIN_W-1:0] self_g, social_g;
    swarm_res_t        pending[$];
    int                errors;

    function new();
      for (int i = 0; i < DIMENSIONS_DEF; i++) begin
        pos[i] = '0; vel[i] = '0; pbest[i] = '0; lbest[i] = '0;
        lo_b[i] = '0; hi_b[i] = '0;
      end
      cur_fit = '0; best_fit = '0; local_fit = '0;
      maximize = MAXIMIZE_RST; chi = CHI_RST; self_g = SELF_RST; social_g = SOCIAL_RST;
      errors = 0;
    endfunction

    function void set_reg(reg_e r, logic [31:0] d);
      case (r)
        REG_MAXIMIZE: maximize = d[0];
        REG_CHI:      chi = d[CHI_W-1:0];
        REG_SELF:     self_g = d[GAIN_W-1:0];
        REG_SOCIAL:   social_g = d[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function void copy_position();
      for (int i = 0; i < DIMENSIONS_DEF; i++) begin
        pbest[i] = pos[i];
        lbest[i] = pos[i];
      end
    endfunction

    // Work out the result of one accepted command and queue it.
    function void note_command(swarm_cmd_t c);
      swarm_res_t e;
      longint x, v, g, k1, k2, t1, t2, s;
      e = '{idx: c.idx, value: '0, best_fit: '0, local_fit: '0, improved: 1'b0, hit: 1'b0};
      case (c.op)
        OP_LOAD_BOUNDS: begin
          lo_b[c.idx] = c.val_a;
          hi_b[c.idx] = c.val_b;
        end
        OP_INIT_ELEM: begin
          pos[c.idx] = c.val_a;
          vel[c.idx] = c.val_b;
        end
        OP_INIT_FIT: begin
          cur_fit = c.fit; best_fit = c.fit; local_fit = c.fit;
          copy_position();
        end
        OP_MOVE: begin
          x = pos[c.idx];
          v = vel[c.idx];
          g = c.use_global ? longint'(c.val_a) : longint'(lbest[c.idx]);
          k1 = (longint'(self_g) * longint'(c.r_self)) >>> 16;
          k2 = (longint'(social_g) * longint'(c.r_social)) >>> 16;
          t1 = (k1 * (longint'(pbest[c.idx]) - x)) >>> 16;
          t2 = (k2 * (g - x)) >>> 16;
          s = v + t1 + t2;
          v = (longint'(chi) * s) >>> 16;
          if (v > 64'sd2147483647) v = 64'sd2147483647;
          if (v < -64'sd2147483648) v = -64'sd2147483648;
          x = x + v;
          // Lower bound first; crossed bounds apply both clamps.
          if (x < longint'(lo_b[c.idx])) begin
            x = lo_b[c.idx];
            v = (-v) >>> 1;
            e.hit = 1'b1;
          end
          if (x > longint'(hi_b[c.idx])) begin
            x = hi_b[c.idx];
            v = (-v) >>> 1;
            e.hit = 1'b1;
          end
          pos[c.idx] = x[31:0];
          vel[c.idx] = v[31:0];
          e.value = x[31:0];
        end
        OP_REPORT: begin
          cur_fit = c.fit;
          if (maximize ? (c.fit > best_fit) : (c.fit < best_fit)) begin
            best_fit = c.fit;
            local_fit = c.fit;
            copy_position();
            e.improved = 1'b1;
          end
        end
        OP_SET_LOCAL: begin
          lbest[c.idx] = c.val_a;
          local_fit = c.fit;
        end
        OP_READ_BEST: e.value = pbest[c.idx];
        default: ;
      endcase
      e.best_fit = best_fit;
      e.local_fit = local_fit;
      pending.push_back(e);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch in %s at %0t: got %h, expected %h", what, $realtime, got, want);
      errors++;
    endtask

    // Compare one result from the block with the oldest prediction.
    task check_result(swarm_res_t r);
      swarm_res_t e;
      if (pending.size() == 0) begin
        report("unexpected result", r.value, 32'h0);
      end else begin
        e = pending.pop_front();
        if (r.idx !== e.idx) report("echo_index", r.idx, e.idx);
        if (r.value !== e.value) report("result_value", r.value, e.value);
        if (r.best_fit !== e.best_fit) report("best_fitness", r.best_fit, e.best_fit);
        if (r.local_fit !== e.local_fit) report("local_best_fitness", r.local_fit, e.local_fit);
        if (r.improved !== e.improved) report("improved", r.improved, e.improved);
        if (r.hit !== e.hit) report("bound_hit", r.hit, e.hit);
      end
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [135:0]       s_axis_tdata = '0;
  logic [3:0]         s_axis_tuser = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [103:0]       m_axis_tdata;
  logic [1:0]         m_axis_tuser;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  particle_scoreboard sb = new();
  int unsigned cycles = 0;
  int          tx_max = 7;
  int          rx_max = 7;
  bit          rx_hold = 1'b0;

  particle_swarm_update uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #2 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("particle_swarm_update_tb: FAIL");
      $finish;
    end
  end

  // Offer one command after a random gap and wait for its transaction.
  task send_command(swarm_cmd_t c);
    int gap;
    gap = (tx_max > 0) ? $urandom_range(0, tx_max) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, c.r_social, c.r_self, c.fit, c.val_b, c.val_a, c.idx};
    s_axis_tuser <= {c.use_global, c.op};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(c);
  endtask

  task apb_write(reg_e r, logic [31:0] d);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * int'(r));
    pwdata <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(r, d);
  endtask

  // Let every predicted result drain, then the block's longest internal sweep.
  task drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task configure(logic mx, logic [31:0] chi, logic [31:0] c1, logic [31:0] c2);
    drain();
    apb_write(REG_MAXIMIZE, {31'b0, mx});
    apb_write(REG_CHI, chi);
    apb_write(REG_SELF, c1);
    apb_write(REG_SOCIAL, c2);
  endtask

  function automatic logic signed [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return $urandom;
    return $signed($urandom_range(0, 200 << 16)) - (100 << 16);
  endfunction

  function automatic logic [RAND_W-1:0] pick_factor();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 131071);
    return $urandom_range(0, 65536);
  endfunction

  function automatic swarm_cmd_t make_cmd(logic [2:0] op, int idx, logic signed [31:0] a,
                                          logic signed [31:0] b, logic signed [31:0] f,
                                          logic [RAND_W-1:0] r1, logic [RAND_W-1:0] r2,
                                          logic ug);
    swarm_cmd_t c;
    c.op = op; c.idx = idx; c.val_a = a; c.val_b = b; c.fit = f;
    c.r_self = r1; c.r_social = r2; c.use_global = ug;
    return c;
  endfunction

  // Mostly moves and reports on an initialised particle, with some noise.
  function automatic swarm_cmd_t random_cmd();
    swarm_cmd_t c;
    logic signed [31:0] t;
    int sel;
    c = make_cmd(OP_MOVE, $urandom_range(0, 31), pick_value(), pick_value(), pick_value(),
                 pick_factor(), pick_factor(), $urandom_range(0, 1));
    sel = $urandom_range(0, 99);
    if (sel < 50) c.op = OP_MOVE;
    else if (sel < 62) c.op = OP_REPORT;
    else if (sel < 70) c.op = OP_SET_LOCAL;
    else if (sel < 80) c.op = OP_READ_BEST;
    else if (sel < 88) c.op = OP_INIT_ELEM;
    else if (sel < 94) begin
      c.op = OP_LOAD_BOUNDS;
      if (c.val_a > c.val_b && $urandom_range(0, 4) != 0) begin
        t = c.val_a; c.val_a = c.val_b; c.val_b = t;
      end
    end else if (sel < 97) c.op = OP_INIT_FIT;
    else c.op = OP_UNUSED;
    return c;
  endfunction

  // Result side: random stalls plus one long hold-off on request.
  initial begin
    int gap;
    swarm_res_t r;
    forever begin
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      gap = (rx_max > 0) ? $urandom_range(0, rx_max) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      r.idx = m_axis_tdata[4:0];
      r.value = m_axis_tdata[36:5];
      r.best_fit = m_axis_tdata[68:37];
      r.local_fit = m_axis_tdata[100:69];
      r.improved = m_axis_tuser[0];
      r.hit = m_axis_tuser[1];
      sb.check_result(r);
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every dimension gets bounds and a start point before any copy reads them.
    for (int i = 0; i < DIMENSIONS_DEF; i++) begin
      send_command(make_cmd(OP_LOAD_BOUNDS, i, -(50 << 16), 50 << 16, 0, 0, 0, 0));
      send_command(make_cmd(OP_INIT_ELEM, i, pick_value() >>> 2, pick_value() >>> 4,
                            0, 0, 0, 0));
    end
    send_command(make_cmd(OP_INIT_FIT, 0, 0, 0, 32'sd1000, 0, 0, 0));

    // Directed cases: extremes, every operation and the corner behaviours.
    send_command(make_cmd(OP_LOAD_BOUNDS, 31, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 0));
    send_command(make_cmd(OP_INIT_ELEM, 31, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0, 0));
    send_command(make_cmd(OP_MOVE, 31, 32'h8000_0000, 0, 0, 65536, 65536, 1));
    send_command(make_cmd(OP_INIT_ELEM, 30, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0));
    send_command(make_cmd(OP_MOVE, 30, 32'h7fff_ffff, 0, 0, 131071, 131071, 1));
    send_command(make_cmd(OP_MOVE, 30, 0, 0, 0, 0, 0, 0));
    // Lower bound above the upper: the result is clamped to the upper bound.
    send_command(make_cmd(OP_LOAD_BOUNDS, 5, 10 << 16, -(10 << 16), 0, 0, 0, 0));
    send_command(make_cmd(OP_MOVE, 5, 0, 0, 0, 40000, 40000, 0));
    send_command(make_cmd(OP_UNUSED, 7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                          131071, 131071, 1));
    send_command(make_cmd(OP_REPORT, 0, 0, 0, 32'sd1000, 0, 0, 0));
    send_command(make_cmd(OP_REPORT, 0, 0, 0, 32'h8000_0000, 0, 0, 0));
    send_command(make_cmd(OP_REPORT, 0, 0, 0, 32'h7fff_ffff, 0, 0, 0));
    send_command(make_cmd(OP_SET_LOCAL, 31, 32'h7fff_ffff, 0, 32'h7fff_ffff, 0, 0, 0));
    send_command(make_cmd(OP_MOVE, 31, 0, 0, 0, 65536, 65536, 0));
    send_command(make_cmd(OP_READ_BEST, 31, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(OP_READ_BEST, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(OP_INIT_FIT, 3, 0, 0, 32'h8000_0000, 0, 0, 0));

    // Random phases, each under its own gain setting.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: configure(1'b1, 65536, 262144, 262144);
        2: configure(1'b0, 0, 0, 0);
        3: configure(1'b1, 32'h1ffff, 32'h7ffff, 32'h7ffff);
        4: configure(1'b0, 32768, 65536, 200000);
        5: configure(1'b1, 47748, 134349, 134349);
        default: ;
      endcase
      tx_max = (ph == 2) ? 0 : 7;
      rx_max = (ph == 2) ? 0 : 7;
      for (int n = 0; n < 300; n++) begin
        // Long result hold-off while commands keep coming back to back.
        if (ph == 1 && n == 100) begin
          rx_hold = 1'b1;
          tx_max = 0;
        end
        if (ph == 1 && n == 160) tx_max = 7;
        // Sender waits for an empty pipeline once.
        if (ph == 4 && n == 150) begin
          s_axis_tvalid <= 1'b0;
          while (sb.pending.size() != 0) @(posedge clk_i);
        end
        send_command(random_cmd());
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("particle_swarm_update_tb: PASS");
    end else begin
      $display("particle_swarm_update_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: particle_swarm_update.f
+incdir+design
design/psu_pkg.sv
design/psu_regs.sv
design/psu_ctrl.sv
design/psu_dp.sv
design/particle_swarm_update.sv
tb/particle_swarm_update_tb.sv
